@@ rtl/tcp_ack_division_tracker_defines.svh @@
// assertion macros for the tcp ack division tracker
// used by rtl modules that carry concurrent checks; no other dependencies
`ifndef TCP_ACK_DIVISION_TRACKER_DEFINES_SVH
`define TCP_ACK_DIVISION_TRACKER_DEFINES_SVH

// same-cycle implication
`define TCPAD_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("tcpad check failed");

// next-cycle implication
`define TCPAD_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("tcpad check failed");

`endif

@@ rtl/tcpad_pkg.sv @@
// shared types and constants for the tcp ack division tracker
// no dependencies; imported by every rtl module of the block
package tcpad_pkg;

   localparam int INDEX_BITS = 16;
   localparam int SLOT_COUNT = 1 << INDEX_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] HASH_SEED = 16'hbeef;
   localparam logic [31:0] RECIP_THIRD = 32'haaaaaaab;
   localparam int THIRD_SHIFT = 33;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPLIT_LIMIT = 1'd1;
   localparam logic [31:0] GAP_THRESHOLD_RESET = 32'd1000;
   localparam logic [9:0] SPLIT_LIMIT_RESET = 10'd20;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_TRACKED = 3'd1;
   localparam logic [2:0] EV_OVERLAP = 3'd2;
   localparam logic [2:0] EV_CLOSED = 3'd3;
   localparam logic [2:0] EV_LIMIT = 3'd4;

   localparam logic [10:0] SPLIT_STEP = 11'd2;

   typedef struct packed {
      logic        eligible;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic        syn_flag;
      logic        fin_flag;
      logic        rst_flag;
      logic        ack_flag;
      logic [31:0] ack_number;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] ack_value;
      logic [2:0]  event_res;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_SYN,
      OP_CLOSE,
      OP_ACK
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [INDEX_BITS-1:0] index;
      logic [31:0]           dest_address;
      logic [15:0]           source_port;
      logic [15:0]           dest_port;
      logic [31:0]           ack_number;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] address;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] last_ack;
      logic        ack_seen;
      logic [10:0] split_count;
   } slot_type;

   typedef struct packed {
      logic [31:0] gap_threshold;
      logic [9:0]  split_limit;
   } csr_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_INS1,
      ST_INS2,
      ST_ORIG
   } state_type;

endpackage

@@ rtl/tcpad_front.sv @@
// front end: classifies an accepted header and hashes its tuple to a slot
// depends on tcpad_pkg
module tcpad_front (
   input  logic                accept,
   input  tcpad_pkg::req_type  req_item,
   output logic                push,
   output tcpad_pkg::entry_type entry
);
   import tcpad_pkg::*;

   logic [15:0] hash;
   op_type      op;

   assign hash = HASH_SEED ^ req_item.dest_address[31:16] ^ req_item.dest_address[15:0]
                 ^ req_item.source_port ^ req_item.dest_port;

   always_comb begin
      if (!req_item.eligible) begin
         op = OP_PASS;
      end else if (req_item.syn_flag) begin
         op = OP_SYN;
      end else if (req_item.fin_flag || req_item.rst_flag) begin
         op = OP_CLOSE;
      end else if (req_item.ack_flag) begin
         op = OP_ACK;
      end else begin
         op = OP_PASS;
      end
   end

   assign push = accept;
   assign entry.op = op;
   assign entry.index = hash[INDEX_BITS-1:0];
   assign entry.dest_address = req_item.dest_address;
   assign entry.source_port = req_item.source_port;
   assign entry.dest_port = req_item.dest_port;
   assign entry.ack_number = req_item.ack_number;

endmodule

@@ rtl/tcpad_queue.sv @@
// short transaction queue between the front end and the table engine
// depends on tcpad_pkg
module tcpad_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  tcpad_pkg::entry_type         push_entry,
   input  logic                         pop,
   output tcpad_pkg::entry_type         head,
   output tcpad_pkg::queue_status_type  status
);
   import tcpad_pkg::*;

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head = slots_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

endmodule

@@ rtl/tcpad_back.sv @@
// table engine: connection table, ack gap split and result sequencing
// depends on tcpad_pkg and tcp_ack_division_tracker_defines.svh
`include "tcp_ack_division_tracker_defines.svh"

module tcpad_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tcpad_pkg::csr_type           csr,
   input  tcpad_pkg::entry_type         head,
   input  tcpad_pkg::queue_status_type  q_status,
   output logic                         pop,
   output tcpad_pkg::back_status_type   status,
   output logic                         rsp_strobe,
   output tcpad_pkg::rsp_type           rsp_item
);
   import tcpad_pkg::*;

   slot_type              slot_mem_ff [SLOT_COUNT];
   slot_type              slot_rd_ff;
   logic                  slot_wr_en;
   logic [INDEX_BITS-1:0] slot_wr_idx;
   slot_type              slot_wr_data;
   logic                  eval_wr;
   slot_type              eval_data;

   logic                  clearing_ff;
   logic [INDEX_BITS-1:0] clear_idx_ff;

   state_type   state_ff, state_in;
   entry_type   cur_ff, cur_in;
   logic [31:0] gap_ff, gap_in;
   logic [2:0]  ev_ff, ev_in;
   logic [63:0] prod_ff;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_ff, rsp_in;

   logic        match;
   logic [31:0] gap;
   logic [10:0] new_count;
   logic [10:0] limit_ext;
   logic        split_ok;
   logic [30:0] third;

   assign match = slot_rd_ff.valid && slot_rd_ff.address == cur_ff.dest_address
                  && slot_rd_ff.src_port == cur_ff.source_port
                  && slot_rd_ff.dst_port == cur_ff.dest_port;
   assign gap = cur_ff.ack_number - slot_rd_ff.last_ack;
   assign new_count = slot_rd_ff.split_count + SPLIT_STEP;
   assign limit_ext = {1'b0, csr.split_limit};
   assign split_ok = (gap > csr.gap_threshold) && (slot_rd_ff.split_count < limit_ext);
   assign third = prod_ff[63:THIRD_SHIFT];

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      cur_in = cur_ff;
      gap_in = gap_ff;
      ev_in = ev_ff;
      eval_wr = 1'b0;
      eval_data = slot_rd_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!clearing_ff && !q_status.empty) begin
               pop = 1'b1;
               cur_in = head;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ev_in = EV_NONE;
            state_in = ST_IDLE;
            unique case (cur_ff.op)
               OP_SYN: begin
                  if (!slot_rd_ff.valid || match) begin
                     eval_wr = 1'b1;
                     eval_data.valid = 1'b1;
                     eval_data.address = cur_ff.dest_address;
                     eval_data.src_port = cur_ff.source_port;
                     eval_data.dst_port = cur_ff.dest_port;
                     eval_data.ack_seen = 1'b0;
                     eval_data.split_count = '0;
                     ev_in = EV_TRACKED;
                  end else begin
                     ev_in = EV_OVERLAP;
                  end
               end
               OP_CLOSE: begin
                  if (match) begin
                     eval_wr = 1'b1;
                     eval_data.valid = 1'b0;
                     ev_in = EV_CLOSED;
                  end
               end
               OP_ACK: begin
                  if (match) begin
                     eval_wr = 1'b1;
                     eval_data.last_ack = cur_ff.ack_number;
                     eval_data.ack_seen = 1'b1;
                     if (slot_rd_ff.ack_seen && split_ok) begin
                        eval_data.split_count = new_count;
                        gap_in = gap;
                        state_in = ST_DIV;
                        if (new_count >= limit_ext) begin
                           eval_data.valid = 1'b0;
                           ev_in = EV_LIMIT;
                        end
                     end
                  end
               end
               OP_PASS: begin
               end
               default: begin
               end
            endcase
            if (state_in == ST_IDLE) begin
               rsp_strobe_in = 1'b1;
               rsp_in.kind = 1'b1;
               rsp_in.ack_value = cur_ff.ack_number;
               rsp_in.event_res = ev_in;
               rsp_in.last = 1'b1;
            end
         end
         ST_DIV: begin
            state_in = ST_INS1;
         end
         ST_INS1: begin
            rsp_strobe_in = 1'b1;
            rsp_in.kind = 1'b0;
            rsp_in.ack_value = cur_ff.ack_number - {third, 1'b0};
            rsp_in.event_res = ev_ff;
            rsp_in.last = 1'b0;
            state_in = ST_INS2;
         end
         ST_INS2: begin
            rsp_strobe_in = 1'b1;
            rsp_in.kind = 1'b0;
            rsp_in.ack_value = cur_ff.ack_number - {1'b0, third};
            rsp_in.event_res = ev_ff;
            rsp_in.last = 1'b0;
            state_in = ST_ORIG;
         end
         ST_ORIG: begin
            rsp_strobe_in = 1'b1;
            rsp_in.kind = 1'b1;
            rsp_in.ack_value = cur_ff.ack_number;
            rsp_in.event_res = ev_ff;
            rsp_in.last = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         clearing_ff <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (clearing_ff) begin
            clear_idx_ff <= clear_idx_ff + 1'b1;
            if (clear_idx_ff == {INDEX_BITS{1'b1}}) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      gap_ff <= gap_in;
      ev_ff <= ev_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_DIV) begin
         prod_ff <= {32'd0, gap_ff} * {32'd0, RECIP_THIRD};
      end
   end

   // clearing pass owns the write port after reset
   assign slot_wr_en = clearing_ff || eval_wr;
   assign slot_wr_idx = clearing_ff ? clear_idx_ff : cur_ff.index;
   assign slot_wr_data = clearing_ff ? slot_type'('0) : eval_data;

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem_ff[slot_wr_idx] <= slot_wr_data;
      end
      if (pop) begin
         slot_rd_ff <= slot_mem_ff[head.index];
      end
   end

   assign status.clearing = clearing_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   `TCPAD_ASSERT_IMP(a_no_rsp_clearing, clock, reset, clearing_ff, !rsp_strobe_ff)
   `TCPAD_ASSERT_NXT(a_ins1_out, clock, reset, state_ff == ST_INS1, rsp_strobe_ff && !rsp_ff.kind && !rsp_ff.last)
   `TCPAD_ASSERT_IMP(a_last_kind, clock, reset, rsp_strobe_ff, rsp_ff.kind == rsp_ff.last)
   `TCPAD_ASSERT_NXT(a_write_then, clock, reset, slot_wr_en && !clearing_ff, state_ff == ST_IDLE || state_ff == ST_DIV)
   `TCPAD_ASSERT_IMP(a_split_event, clock, reset, rsp_strobe_ff && !rsp_ff.kind, rsp_ff.event_res == EV_NONE || rsp_ff.event_res == EV_LIMIT)

endmodule

@@ rtl/tcp_ack_division_tracker.sv @@
// top level of the tcp ack division tracker: csr registers and module wiring
// depends on tcpad_pkg, tcpad_front, tcpad_queue and tcpad_back
//
// usage:
//   input: drive req_item and raise start; the header is taken at a rising
//   edge where start is high and busy is low. busy is high while the
//   two-entry queue in front of the table engine is full, and during the
//   table clearing pass.
//   output: each result is on rsp_item for exactly one cycle with rsp_strobe
//   high; the receiver cannot stall, results are never held back.
//   one header gives one result (original packet, last set) or three results
//   (two inserted acks, then the original) on consecutive cycles.
//   engine: the table engine works on one header at a time, and the queue
//   in front of it takes new headers until full; per header it steps through
//   table read, evaluate and write, and for a split also a multiply by the
//   reciprocal of three and three result states.
//   csr: csr_write_enable with csr_index and csr_data writes a register;
//   write only while idle.
//   reset: synchronous; the csr registers return to their defaults and a
//   clearing pass over all 65536 slots (one slot a cycle) runs with busy high.
module tcp_ack_division_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  tcpad_pkg::req_type                     req_item,
   output logic                                   rsp_strobe,
   output tcpad_pkg::rsp_type                     rsp_item,
   input  logic                                   csr_write_enable,
   input  logic [tcpad_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [31:0]                            csr_data
);
   import tcpad_pkg::*;

   csr_type          csr_ff;
   logic             accept;
   logic             push;
   entry_type        entry;
   logic             pop;
   entry_type        head;
   queue_status_type q_status;
   back_status_type  b_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gap_threshold <= GAP_THRESHOLD_RESET;
         csr_ff.split_limit <= SPLIT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAP_THRESHOLD: csr_ff.gap_threshold <= csr_data;
            CSR_SPLIT_LIMIT: csr_ff.split_limit <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   assign busy = q_status.full || b_status.clearing;
   assign accept = start && !busy;

   tcpad_front u_front (
      .accept   (accept),
      .req_item (req_item),
      .push     (push),
      .entry    (entry)
   );

   tcpad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   tcpad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .status     (b_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

@@ tb/tcp_ack_division_tracker_tb.sv @@
// self-checking testbench for tcp_ack_division_tracker: directed table, then random phases
// keeps its own connection table predictor; depends on tcpad_pkg and the rtl top level
module tcp_ack_division_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpad_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int IDLE_WAIT = 12;
   localparam int DRAIN_CYCLES = 20;
   localparam int POOL_SIZE = 6;
   localparam int DIR_ROWS = 26;
   localparam int DIR_LIMIT_ROW = 22;

   localparam logic [3:0] FL_NONE = 4'b0000;
   localparam logic [3:0] FL_SYN = 4'b1000;
   localparam logic [3:0] FL_FIN = 4'b0100;
   localparam logic [3:0] FL_RST = 4'b0010;
   localparam logic [3:0] FL_ACK = 4'b0001;

   localparam logic [31:0] TA_ADDR = 32'hffffffff;
   localparam logic [15:0] TA_SP = 16'hffff;
   localparam logic [15:0] TA_DP = 16'hffff;
   localparam logic [31:0] TB_ADDR = 32'hfffffffe;
   localparam logic [15:0] TB_SP = 16'hfffe;
   localparam logic [15:0] TB_DP = 16'hffff;
   localparam logic [31:0] TC_ADDR = 32'h0;
   localparam logic [15:0] TC_SP = 16'h0;
   localparam logic [15:0] TC_DP = 16'h0;

   typedef struct {
      req_type    item;
      bit         typed;
      logic [2:0] ev;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_item;
   logic                      rsp_strobe;
   rsp_type                   rsp_item;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0]               csr_data;

   rsp_type     pending_packets[$];
   slot_type    conn_table[int unsigned];
   logic [31:0] cfg_gap_threshold = GAP_THRESHOLD_RESET;
   logic [9:0]  cfg_split_limit = SPLIT_LIMIT_RESET;
   int          error_count = 0;
   int unsigned cycle_count = 0;

   logic [31:0] pool_addr[POOL_SIZE];
   logic [15:0] pool_sp[POOL_SIZE];
   logic [15:0] pool_dp[POOL_SIZE];
   logic [31:0] pool_ack[POOL_SIZE];

   tcp_ack_division_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_type mk_req(logic elig, logic [31:0] addr, logic [15:0] sp,
                                      logic [15:0] dp, logic [3:0] flags, logic [31:0] ackno);
      return '{eligible: elig, dest_address: addr, source_port: sp, dest_port: dp,
               syn_flag: flags[3], fin_flag: flags[2], rst_flag: flags[1],
               ack_flag: flags[0], ack_number: ackno};
   endfunction

   dir_row_type dir_tab[DIR_ROWS] = '{
      '{mk_req(1'b0, TA_ADDR, TA_SP, TA_DP, FL_SYN | FL_FIN | FL_RST | FL_ACK, 32'hffffffff),
        1'b1, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_SYN, 32'h0), 1'b1, EV_TRACKED},
      '{mk_req(1'b1, TB_ADDR, TB_SP, TB_DP, FL_SYN | FL_ACK, 32'h12345678), 1'b1, EV_OVERLAP},
      '{mk_req(1'b1, TB_ADDR, TB_SP, TB_DP, FL_ACK, 32'd5), 1'b1, EV_NONE},
      '{mk_req(1'b1, TB_ADDR, TB_SP, TB_DP, FL_FIN, 32'd6), 1'b1, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_ACK, 32'd0), 1'b1, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_ACK, 32'd1000), 1'b1, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_ACK, 32'd2001), 1'b0, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_ACK, 32'd0), 1'b0, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_NONE, 32'd7), 1'b1, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_SYN | FL_FIN | FL_ACK, 32'd9), 1'b1, EV_TRACKED},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_FIN | FL_RST, 32'd10), 1'b1, EV_CLOSED},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_RST, 32'd11), 1'b1, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_SYN | FL_ACK, 32'd0), 1'b1, EV_TRACKED},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_ACK, 32'hffffffff), 1'b1, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_ACK, 32'hffffffff), 1'b1, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_ACK, 32'h10000000), 1'b0, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_SYN, 32'd0), 1'b1, EV_OVERLAP},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_ACK, 32'd100), 1'b1, EV_NONE},
      '{mk_req(1'b1, TA_ADDR, TA_SP, TA_DP, FL_RST | FL_ACK, 32'd0), 1'b1, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_RST, 32'd1), 1'b1, EV_CLOSED},
      '{mk_req(1'b0, TC_ADDR, TC_SP, TC_DP, FL_SYN, 32'd2), 1'b1, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_SYN, 32'd0), 1'b1, EV_TRACKED},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_ACK, 32'd0), 1'b1, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_ACK, 32'h00100000), 1'b0, EV_NONE},
      '{mk_req(1'b1, TC_ADDR, TC_SP, TC_DP, FL_ACK, 32'h00200000), 1'b1, EV_NONE}
   };

   function automatic void split_outgoing(req_type t, ref rsp_type outq[$]);
      slot_type              s;
      logic [INDEX_BITS-1:0] idx;
      logic                  match;
      logic [2:0]            ev;
      logic                  split;
      logic [31:0]           gap;
      logic [31:0]           third;
      ev = EV_NONE;
      split = 1'b0;
      third = '0;
      if (t.eligible) begin
         idx = HASH_SEED ^ t.dest_address[31:16] ^ t.dest_address[15:0]
               ^ t.source_port ^ t.dest_port;
         s = conn_table.exists(idx) ? conn_table[idx] : '0;
         match = s.valid && s.address == t.dest_address && s.src_port == t.source_port
                 && s.dst_port == t.dest_port;
         if (t.syn_flag) begin
            if (!s.valid || match) begin
               s.valid = 1'b1;
               s.ack_seen = 1'b0;
               s.split_count = '0;
               s.address = t.dest_address;
               s.src_port = t.source_port;
               s.dst_port = t.dest_port;
               ev = EV_TRACKED;
            end else begin
               ev = EV_OVERLAP;
            end
         end else if (t.fin_flag || t.rst_flag) begin
            if (match) begin
               s.valid = 1'b0;
               ev = EV_CLOSED;
            end
         end else if (t.ack_flag && match) begin
            if (!s.ack_seen) begin
               s.last_ack = t.ack_number;
               s.ack_seen = 1'b1;
            end else begin
               gap = t.ack_number - s.last_ack;
               s.last_ack = t.ack_number;
               if (gap > cfg_gap_threshold && s.split_count < {1'b0, cfg_split_limit}) begin
                  third = gap / 32'd3;
                  split = 1'b1;
                  s.split_count = s.split_count + SPLIT_STEP;
                  if (s.split_count >= {1'b0, cfg_split_limit}) begin
                     s.valid = 1'b0;
                     ev = EV_LIMIT;
                  end
               end
            end
         end
         conn_table[idx] = s;
      end
      if (split) begin
         outq.push_back('{kind: 1'b0, ack_value: t.ack_number - (third << 1), event_res: ev,
                          last: 1'b0});
         outq.push_back('{kind: 1'b0, ack_value: t.ack_number - third, event_res: ev,
                          last: 1'b0});
      end
      outq.push_back('{kind: 1'b1, ack_value: t.ack_number, event_res: ev, last: 1'b1});
   endfunction

   task automatic send_packet(req_type t, bit typed, logic [2:0] ev, int idle_pct);
      rsp_type predicted[$];
      int      gap;
      gap = 0;
      while (gap < 30 && int'($urandom_range(99)) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= t;
      do @(posedge clock); while (busy);
      split_outgoing(t, predicted);
      if (typed)
         pending_packets.push_back('{kind: 1'b1, ack_value: t.ack_number, event_res: ev,
                                    last: 1'b1});
      else
         foreach (predicted[i])
            pending_packets.push_back(predicted[i]);
   endtask

   task automatic write_csr_pair(logic [31:0] thr, logic [9:0] lim);
      start <= 1'b0;
      while (pending_packets.size() != 0 || busy)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_GAP_THRESHOLD;
      csr_data <= thr;
      @(posedge clock);
      csr_index <= CSR_SPLIT_LIMIT;
      csr_data <= {22'd0, lim};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_gap_threshold = thr;
      cfg_split_limit = lim;
   endtask

   task automatic new_pool();
      logic [15:0] x;
      for (int k = 0; k < POOL_SIZE; k++) begin
         if (k % 2 == 0) begin
            pool_addr[k] = $urandom;
            pool_sp[k] = $urandom;
            pool_dp[k] = $urandom;
         end else begin
            // same slot as the previous tuple, different connection
            x = $urandom_range(1, 65535);
            pool_addr[k] = pool_addr[k-1] ^ {16'h0, x};
            pool_sp[k] = pool_sp[k-1] ^ x;
            pool_dp[k] = pool_dp[k-1];
         end
         pool_ack[k] = $urandom;
      end
   endtask

   task automatic gen_packet(output req_type t);
      logic [127:0] raw;
      logic [3:0]   flags;
      logic [31:0]  delta;
      logic [31:0]  ackno;
      int           k;
      int           r;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = $urandom_range(99);
      if (r < 5) begin
         t = raw[$bits(req_type)-1:0];
         return;
      end
      k = $urandom_range(POOL_SIZE - 1);
      r = $urandom_range(99);
      ackno = $urandom;
      if (r < 14) begin
         flags = FL_SYN | raw[2:0];
      end else if (r < 22) begin
         flags = raw[4] ? FL_FIN : (raw[5] ? FL_RST : (FL_FIN | FL_RST));
         flags[0] = raw[6];
      end else if (r < 94) begin
         flags = FL_ACK;
         case ($urandom_range(3))
            0: delta = $urandom_range(0, (cfg_gap_threshold > 5000) ? 5000 : cfg_gap_threshold);
            1: delta = cfg_gap_threshold + 32'd1 + $urandom_range(0, 3000);
            2: delta = $urandom;
            default: delta = raw[7] ? cfg_gap_threshold : cfg_gap_threshold + 32'd1;
         endcase
         ackno = pool_ack[k] + delta;
         pool_ack[k] = ackno;
      end else begin
         flags = raw[11:8];
      end
      t = mk_req($urandom_range(99) >= 4, pool_addr[k], pool_sp[k], pool_dp[k], flags, ackno);
   endtask

   task automatic run_phase(logic [31:0] thr, logic [9:0] lim, int idle_pct, int count);
      req_type t;
      write_csr_pair(thr, lim);
      new_pool();
      repeat (count) begin
         gen_packet(t);
         send_packet(t, 1'b0, EV_NONE, idle_pct);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_packets.size() == 0) begin
            $display("%0t: unexpected transaction kind=%0d ack=%h ev=%0d last=%0d", $time,
                     rsp_item.kind, rsp_item.ack_value, rsp_item.event_res, rsp_item.last);
            error_count++;
         end else begin
            want = pending_packets.pop_front();
            if (rsp_item.kind !== want.kind || rsp_item.ack_value !== want.ack_value ||
                rsp_item.event_res !== want.event_res || rsp_item.last !== want.last) begin
               $display("%0t: mismatch expected kind=%0d ack=%h ev=%0d last=%0d", $time,
                        want.kind, want.ack_value, want.event_res, want.last);
               $display("%0t:          actual   kind=%0d ack=%h ev=%0d last=%0d", $time,
                        rsp_item.kind, rsp_item.ack_value, rsp_item.event_res, rsp_item.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_GAP_THRESHOLD;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         // limit reached needs a small split limit
         if (i == DIR_LIMIT_ROW)
            write_csr_pair(GAP_THRESHOLD_RESET, 10'd2);
         send_packet(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].ev, 0);
      end

      run_phase(GAP_THRESHOLD_RESET, SPLIT_LIMIT_RESET, 0, 80);
      run_phase(32'h0, 10'd1023, 86, 70);
      run_phase(32'hffffffff, 10'd5, 23, 60);
      run_phase(32'd50, 10'd1, 0, 70);
      run_phase(32'd100, 10'd0, 86, 60);
      run_phase($urandom_range(200, 20000), $urandom_range(2, 40), 23, 60);
      run_phase(32'd3000, 10'd8, 0, 60);

      start <= 1'b0;
      while (pending_packets.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
